// ===== hdl/depq_pkg.sv =====
// ============================================================================
// depq_pkg
// Shared types, codes and helpers of the double-ended priority queue.
// ============================================================================
package depq_pkg;

   localparam int DATA_W           = 32;
   localparam int ACTION_W         = 2;
   localparam int COUNT_W          = 5;
   localparam int DEFAULT_CAPACITY = 16;

   // Action codes. The fourth code is unused and changes nothing.
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP_MIN = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_MAX = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_REMOVAL = -32'sd1;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      logic                     underflow;
      logic                     overflow;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [DATA_W-1:0] current_min;
      logic signed [DATA_W-1:0] current_max;
   } rsp_type;

   // Per-cycle command broadcast to every cell of one chain.
   typedef struct packed {
      logic insert;      // place the new value, shifting the entries that sort after it right
      logic pop_front;   // drop the head entry, shifting everything left
      logic descending;  // chain keeps its entries in descending order
   } cell_ctl_type;

   function automatic logic less_signed(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b);
      return a < b;
   endfunction

endpackage

// ===== hdl/depq_cell.sv =====
// ============================================================================
// depq_cell
// One slot of a sorted chain: holds one entry and trades with its neighbors.
// ============================================================================
module depq_cell #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                              clock,
   input  depq_pkg::cell_ctl_type            ctl,
   input  logic [IDX_W-1:0]                  index,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [depq_pkg::DATA_W-1:0] new_value,
   input  logic signed [depq_pkg::DATA_W-1:0] left_entry,
   input  logic                              left_after,
   input  logic signed [depq_pkg::DATA_W-1:0] right_entry,
   output logic signed [depq_pkg::DATA_W-1:0] entry,
   output logic                              after
);
   import depq_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     occupied;
   logic                     at_tail;
   logic                     outranked;

   assign occupied  = CNT_W'(index) < count;
   assign at_tail   = CNT_W'(index) == count;
   // The new value goes in front of this entry; equal values stay ahead of it.
   assign outranked = ctl.descending ? less_signed(entry_ff, new_value)
                                     : less_signed(new_value, entry_ff);
   assign after     = occupied && outranked;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && (after || at_tail)) begin
         entry_in = left_after ? left_entry : new_value;
      end else if (ctl.pop_front) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/depq_chain.sv =====
// ============================================================================
// depq_chain
// A row of cells keeping the stored values sorted, head entry at cell 0.
// ============================================================================
module depq_chain #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                              clock,
   input  depq_pkg::cell_ctl_type            ctl,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [depq_pkg::DATA_W-1:0] new_value,
   output logic signed [depq_pkg::DATA_W-1:0] head
);
   import depq_pkg::*;

   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic                     after_w [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic                     left_after;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = new_value;
         assign left_after = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_w[i-1];
         assign left_after = after_w[i-1];
      end

      // The last cell keeps its own entry on a shift; it is past the count then.
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_mid
         assign right_entry = entry_w[i+1];
      end

      depq_cell #(
         .IDX_W(IDX_W),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .index      (IDX_W'(i)),
         .count      (count),
         .new_value  (new_value),
         .left_entry (left_entry),
         .left_after (left_after),
         .right_entry(right_entry),
         .entry      (entry_w[i]),
         .after      (after_w[i])
      );
   end

   assign head = entry_w[0];

endmodule

// ===== hdl/double_ended_priority_queue_core.sv =====
// ============================================================================
// double_ended_priority_queue_core
// Bounded multiset of signed values with insert, remove-min and remove-max.
// ============================================================================
// A command beat is taken at a rising edge where start is high and busy is
// low; busy never rises, so one command can be issued in every cycle. Each
// command carries an action (insert, remove minimum, remove maximum) and a
// value used only by an insert.
// Every command produces exactly one result beat, shown on rsp_payload
// in the cycle after the command edge and marked by rsp_valid.
// Throughput is one command per cycle; the receiver cannot stall, so it
// must take each result beat in the cycle it is shown.
// The store is two chains of CAPACITY cells holding the same values, one in
// ascending and one in descending order, so the minimum and the maximum are
// always in cell 0 of a chain. An insert lands in both chains together;
// a removal shifts one chain left and just shortens the other through the
// shared count. An insert into a full store is dropped with overflow set; a
// removal from an empty store returns -1 with underflow set.
// Reset empties the store at once (the count goes to zero; cell contents are
// left as they are and are never read past the count) and drops any pending
// result beat.
module double_ended_priority_queue_core #(
   parameter int CAPACITY = depq_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  depq_pkg::req_type req_payload,
   output logic              rsp_valid,
   output depq_pkg::rsp_type rsp_payload
);
   import depq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] removed_ff;
   logic signed [DATA_W-1:0] removed_in;
   logic                     underflow_ff;
   logic                     underflow_in;
   logic                     overflow_ff;
   logic                     overflow_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic                     do_insert;
   logic                     do_pop_min;
   logic                     do_pop_max;
   cell_ctl_type             asc_ctl;
   cell_ctl_type             desc_ctl;
   logic signed [DATA_W-1:0] min_head;
   logic signed [DATA_W-1:0] max_head;

   // Every command completes at its command edge, so the core is never busy.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign empty  = count_ff == '0;

   assign do_insert  = accept && (req_payload.action == ACT_INSERT) && !full;
   assign do_pop_min = accept && (req_payload.action == ACT_POP_MIN) && !empty;
   assign do_pop_max = accept && (req_payload.action == ACT_POP_MAX) && !empty;

   // Removing the minimum shifts the ascending chain; in the descending chain
   // the minimum sits at the tail and falls off when the count drops.
   // Removing the maximum works the other way around.
   assign asc_ctl  = '{insert: do_insert, pop_front: do_pop_min, descending: 1'b0};
   assign desc_ctl = '{insert: do_insert, pop_front: do_pop_max, descending: 1'b1};

   depq_chain #(
      .CAPACITY(CAPACITY),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_asc_chain (
      .clock    (clock),
      .ctl      (asc_ctl),
      .count    (count_ff),
      .new_value(req_payload.value),
      .head     (min_head)
   );

   depq_chain #(
      .CAPACITY(CAPACITY),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_desc_chain (
      .clock    (clock),
      .ctl      (desc_ctl),
      .count    (count_ff),
      .new_value(req_payload.value),
      .head     (max_head)
   );

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop_min || do_pop_max) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result flags and removed value, taken from the heads before the update.
   always_comb begin
      removed_in   = '0;
      underflow_in = 1'b0;
      overflow_in  = 1'b0;
      case (req_payload.action)
         ACT_INSERT: begin
            overflow_in = full;
         end
         ACT_POP_MIN: begin
            underflow_in = empty;
            removed_in   = empty ? EMPTY_REMOVAL : min_head;
         end
         ACT_POP_MAX: begin
            underflow_in = empty;
            removed_in   = empty ? EMPTY_REMOVAL : max_head;
         end
         default: begin
            removed_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff   <= removed_in;
         underflow_ff <= underflow_in;
         overflow_ff  <= overflow_in;
      end
   end

   // Count, minimum and maximum come straight from the updated store.
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_payload.removed_value = removed_ff;
   assign rsp_payload.underflow     = underflow_ff;
   assign rsp_payload.overflow      = overflow_ff;
   assign rsp_payload.entry_count   = COUNT_W'(count_ff);
   assign rsp_payload.current_min   = empty ? '0 : min_head;
   assign rsp_payload.current_max   = empty ? '0 : max_head;

endmodule

// ===== hdl/depq_checker.sv =====
// ============================================================================
// depq_checker
// Port-level checks on the result beats of the priority queue core.
// ============================================================================
module depq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input depq_pkg::rsp_type rsp_payload
);
   import depq_pkg::*;

   // Each accepted command yields exactly one result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("command beat without a result beat");

   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result beat without a command beat");

   // An underflow only happens on an empty store and returns minus one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.underflow) |->
         (rsp_payload.entry_count == '0) &&
         (rsp_payload.removed_value == EMPTY_REMOVAL) &&
         !rsp_payload.overflow)
      else $error("underflow beat is inconsistent");

   // An empty store reports zero peeks; a non-empty one keeps min <= max.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.entry_count == '0)) |->
         (rsp_payload.current_min == '0) && (rsp_payload.current_max == '0))
      else $error("empty store reports nonzero peeks");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.entry_count != '0)) |->
         (rsp_payload.current_min <= rsp_payload.current_max))
      else $error("minimum above maximum");

endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_payload(rsp_payload)
);
